/* hdl/rolh_pkg.sv */
// ----------------------------------------------------------------------------
// rolh_pkg: shared definitions for the ring order lock handoff block
// Ring geometry, routing tables, command and outcome codes, and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package rolh_pkg;

	localparam int NUM_CORES = 64;
	localparam int RING_SIZE = 64;
	localparam int POS_W     = 6;
	localparam int CNT_W     = 7;
	localparam int CMD_W     = 2;
	localparam int OUT_W     = 3;
	localparam int GRP_N     = 8;
	localparam int GRP_W     = 3;
	localparam int GRP_SIZE  = RING_SIZE / GRP_N;

	// largest usable ring count; also the reset value of active_cores
	localparam int MAX_RING = (NUM_CORES < RING_SIZE) ? NUM_CORES : RING_SIZE;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_TRY     = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_code_t;

	localparam logic [OUT_W-1:0] OUT_GRANTED = 3'd0;
	localparam logic [OUT_W-1:0] OUT_QUEUED  = 3'd1;
	localparam logic [OUT_W-1:0] OUT_BUSY    = 3'd2;
	localparam logic [OUT_W-1:0] OUT_FREED   = 3'd3;
	localparam logic [OUT_W-1:0] OUT_HANDOFF = 3'd4;

	// ring position -> core
	localparam logic [POS_W-1:0] RING_ROM [RING_SIZE] = '{
		6'd0,  6'd1,  6'd2,  6'd3,  6'd32, 6'd33, 6'd34, 6'd35,
		6'd4,  6'd5,  6'd6,  6'd7,  6'd36, 6'd37, 6'd38, 6'd39,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd40, 6'd41, 6'd42, 6'd43,
		6'd12, 6'd13, 6'd14, 6'd15, 6'd44, 6'd45, 6'd46, 6'd47,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd56, 6'd57, 6'd58, 6'd59,
		6'd28, 6'd29, 6'd30, 6'd31, 6'd60, 6'd61, 6'd62, 6'd63,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd48, 6'd49, 6'd50, 6'd51,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd52, 6'd53, 6'd54, 6'd55
	};

	// core -> ring position (inverse of RING_ROM)
	localparam logic [POS_W-1:0] RING_INV [RING_SIZE] = '{
		6'd0,  6'd1,  6'd2,  6'd3,  6'd8,  6'd9,  6'd10, 6'd11,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd24, 6'd25, 6'd26, 6'd27,
		6'd48, 6'd49, 6'd50, 6'd51, 6'd56, 6'd57, 6'd58, 6'd59,
		6'd32, 6'd33, 6'd34, 6'd35, 6'd40, 6'd41, 6'd42, 6'd43,
		6'd4,  6'd5,  6'd6,  6'd7,  6'd12, 6'd13, 6'd14, 6'd15,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd28, 6'd29, 6'd30, 6'd31,
		6'd52, 6'd53, 6'd54, 6'd55, 6'd60, 6'd61, 6'd62, 6'd63,
		6'd36, 6'd37, 6'd38, 6'd39, 6'd44, 6'd45, 6'd46, 6'd47
	};

	typedef struct packed {
		logic load;         // capture request fields and ring count
		logic find_pos;     // look up ring position
		logic scan_groups;  // per-group first-waiter search
		logic commit;       // pick winner, update lock state, load result
	} rolh_cmd_t;

	// clamp the programmed count into 1..MAX_RING
	function automatic logic [CNT_W-1:0] ring_count(input logic [CNT_W-1:0] cores);
		logic [CNT_W-1:0] n;
		n = cores;
		if (n == '0)
			n = CNT_W'(1);
		else if (n > CNT_W'(MAX_RING))
			n = CNT_W'(MAX_RING);
		return n;
	endfunction

endpackage

/* hdl/rolh_ctrl.sv */
// ----------------------------------------------------------------------------
// rolh_ctrl: request sequencer
// Walks one request through position lookup, group scan and commit, and
// owns the result valid flag of the output register.
// ----------------------------------------------------------------------------
module rolh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output rolh_pkg::rolh_cmd_t ctl
);
	import rolh_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POS,
		ST_GRP,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl.load        = (state_q == ST_IDLE) && in_valid;
		ctl.find_pos    = (state_q == ST_POS);
		ctl.scan_groups = (state_q == ST_GRP);
		ctl.commit      = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load a committed result, or drop the one taken downstream
			if ((state_q == ST_FIN) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_POS;
				end
				ST_POS: begin
					state_q <= ST_GRP;
				end
				ST_GRP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register frees up
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/rolh_datapath.sv */
// ----------------------------------------------------------------------------
// rolh_datapath: lock state, wait flags and handoff search
// Holds the active core count, lock bit and per-position wait flags, and
// finds the next waiter after the releaser through a two-level search.
// ----------------------------------------------------------------------------
module rolh_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rolh_pkg::rolh_cmd_t              ctl,
	input  logic                             cfg_we,
	input  logic [rolh_pkg::CNT_W-1:0]       cfg_data,
	input  logic [rolh_pkg::CMD_W-1:0]       command,
	input  logic [rolh_pkg::POS_W-1:0]       core_id,
	output logic [rolh_pkg::OUT_W-1:0]       outcome,
	output logic [rolh_pkg::POS_W-1:0]       new_owner
);
	import rolh_pkg::*;

	logic [CNT_W-1:0]     active_cores_q;
	logic                 lock_held_q;
	logic [RING_SIZE-1:0] flags_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [POS_W-1:0]     core_q;
	logic [CNT_W-1:0]     n_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     pos_d;

	logic [RING_SIZE-1:0] hi_vec;
	logic [RING_SIZE-1:0] lo_vec;
	logic [GRP_N-1:0]     hi_any_d, lo_any_d, hi_any_q, lo_any_q;
	logic [GRP_W-1:0]     hi_idx_d [GRP_N];
	logic [GRP_W-1:0]     lo_idx_d [GRP_N];
	logic [GRP_W-1:0]     hi_idx_q [GRP_N];
	logic [GRP_W-1:0]     lo_idx_q [GRP_N];

	logic                 win_found;
	logic [POS_W-1:0]     win_idx;

	logic [OUT_W-1:0]     outcome_d, outcome_q;
	logic [POS_W-1:0]     owner_d, owner_q;
	logic                 lock_d;
	logic                 flag_wr;
	logic                 flag_val;
	logic [POS_W-1:0]     flag_idx;

	assign outcome   = outcome_q;
	assign new_owner = owner_q;

	// a core mapped outside the active ring takes position 0
	always_comb begin
		pos_d = RING_INV[core_q];
		if ({1'b0, pos_d} >= n_q)
			pos_d = '0;
	end

	// eligible waiters after and before the releaser, inside the active ring
	always_comb begin
		for (int q = 0; q < RING_SIZE; q++) begin
			hi_vec[q] = flags_q[q] && (CNT_W'(q) < n_q) && (POS_W'(q) > pos_q);
			lo_vec[q] = flags_q[q] && (CNT_W'(q) < n_q) && (POS_W'(q) < pos_q);
		end
	end

	// first set bit of each group, lowest index wins
	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			hi_any_d[g] = 1'b0;
			lo_any_d[g] = 1'b0;
			hi_idx_d[g] = '0;
			lo_idx_d[g] = '0;
			for (int b = GRP_SIZE - 1; b >= 0; b--) begin
				if (hi_vec[g * GRP_SIZE + b]) begin
					hi_any_d[g] = 1'b1;
					hi_idx_d[g] = GRP_W'(b);
				end
				if (lo_vec[g * GRP_SIZE + b]) begin
					lo_any_d[g] = 1'b1;
					lo_idx_d[g] = GRP_W'(b);
				end
			end
		end
	end

	// positions after the releaser come first, then wrap to the low ones
	always_comb begin
		win_found = 1'b0;
		win_idx   = '0;
		if (|hi_any_q) begin
			win_found = 1'b1;
			for (int g = GRP_N - 1; g >= 0; g--) begin
				if (hi_any_q[g])
					win_idx = {GRP_W'(g), hi_idx_q[g]};
			end
		end else if (|lo_any_q) begin
			win_found = 1'b1;
			for (int g = GRP_N - 1; g >= 0; g--) begin
				if (lo_any_q[g])
					win_idx = {GRP_W'(g), lo_idx_q[g]};
			end
		end
	end

	always_comb begin
		outcome_d = OUT_BUSY;
		owner_d   = '0;
		lock_d    = lock_held_q;
		flag_wr   = 1'b0;
		flag_val  = 1'b0;
		flag_idx  = pos_q;
		case (cmd_q)
			CMD_ACQUIRE: begin
				flag_wr = 1'b1;
				if (!lock_held_q) begin
					lock_d    = 1'b1;
					outcome_d = OUT_GRANTED;
					owner_d   = core_q;
				end else begin
					flag_val  = 1'b1;
					outcome_d = OUT_QUEUED;
				end
			end
			CMD_TRY: begin
				if (!lock_held_q) begin
					lock_d    = 1'b1;
					outcome_d = OUT_GRANTED;
					owner_d   = core_q;
				end
			end
			CMD_RELEASE: begin
				if (win_found) begin
					flag_wr   = 1'b1;
					flag_idx  = win_idx;
					lock_d    = 1'b1;
					outcome_d = OUT_HANDOFF;
					owner_d   = RING_ROM[win_idx];
				end else begin
					lock_d    = 1'b0;
					outcome_d = OUT_FREED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cores_q <= CNT_W'(MAX_RING);
			lock_held_q    <= 1'b0;
			flags_q        <= '0;
		end else begin
			if (cfg_we)
				active_cores_q <= cfg_data;
			if (ctl.commit) begin
				lock_held_q <= lock_d;
				if (flag_wr)
					flags_q[flag_idx] <= flag_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			core_q <= core_id;
			n_q    <= ring_count(active_cores_q);
		end
		if (ctl.find_pos)
			pos_q <= pos_d;
		if (ctl.scan_groups) begin
			hi_any_q <= hi_any_d;
			lo_any_q <= lo_any_d;
			hi_idx_q <= hi_idx_d;
			lo_idx_q <= lo_idx_d;
		end
		if (ctl.commit) begin
			outcome_q <= outcome_d;
			owner_q   <= owner_d;
		end
	end

endmodule

/* hdl/ring_order_lock_handoff.sv */
// ----------------------------------------------------------------------------
// ring_order_lock_handoff: lock manager with ring-order handoff
// One lock shared by up to 64 cores; releases hand the lock to the next
// waiting core in ring order after the releaser.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------
//  in       in_valid / in_stall  command, core_id
//  out      out_valid/out_stall  outcome, new_owner
//  cfg      cfg_valid/cfg_ready  cfg_data (active_cores)
//
//  A request passes from acceptance to its result in the output register
//  through capture, ring position lookup, per-group waiter scan and commit.
//  The sequencer handles one request at a time; the next is taken once
//  the current one commits, even while its result still waits downstream.
//  A commit holds while the output register is full and stalled.
//  Reset frees the lock, clears all wait flags and sets active_cores to 64.
//
module ring_order_lock_handoff (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rolh_pkg::CMD_W-1:0]   command,
	input  logic [rolh_pkg::POS_W-1:0]   core_id,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rolh_pkg::OUT_W-1:0]   outcome,
	output logic [rolh_pkg::POS_W-1:0]   new_owner,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rolh_pkg::CNT_W-1:0]   cfg_data
);
	import rolh_pkg::*;

	rolh_cmd_t ctl;

	assign cfg_ready = 1'b1;

	rolh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	rolh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.command   (command),
		.core_id   (core_id),
		.outcome   (outcome),
		.new_owner (new_owner)
	);

	// an accepted request blocks the input until it commits
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not blocked after request accepted");

	// a fresh result must trace back to an accepted request
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 4))
		else $error("result without matching request");

	// only grants and handoffs name an owner
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (outcome == OUT_QUEUED || outcome == OUT_BUSY ||
			outcome == OUT_FREED)) |-> (new_owner == '0))
		else $error("owner reported on non-grant outcome");

endmodule
